// ----- hdl/bmms_pkg.sv -----
// ---------------------------------------------------------------------------
// bmms_pkg - button multipress mode selector package
// Shared types, register indexes and reset values.
// ---------------------------------------------------------------------------
package bmms_pkg;

    localparam int UPTIME_BITS_DEF = 32;
    localparam int TICK_MS         = 10;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TURNOFF_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MP_TIMEOUT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT   = 2'd3;

    localparam logic [7:0]  RST_TURNOFF_TICKS = 8'd200;
    localparam logic [7:0]  RST_DEBOUNCE_THR  = 8'd190;
    localparam logic [15:0] RST_MP_TIMEOUT    = 16'd1000;
    localparam logic [6:0]  RST_STATE_COUNT   = 7'd4;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_PRESS = 1'b1;

    typedef struct packed {
        logic [7:0]  turnoff_ticks;
        logic [7:0]  debounce_threshold;
        logic [15:0] multipress_timeout_ms;
        logic [6:0]  state_count;
    } cfg_t;

    typedef struct packed {
        logic       shutdown_request;
        logic       led_on;
        logic       publish_valid;
        logic [6:0] published_state;
        logic [6:0] press_count;
    } result_t;

endpackage

// ----- hdl/bmms_core.sv -----
// ---------------------------------------------------------------------------
// bmms_core - press tracking state and per-beat update
// Holds countdown, press counter and elapsed time; computes one result per
// accepted input beat combinationally from the current state.
// ---------------------------------------------------------------------------
module bmms_core #(
    parameter int UPTIME_BITS = bmms_pkg::UPTIME_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bmms_pkg::cfg_t     cfg,
    input  logic               in_fire,
    input  logic               func,
    input  logic               button_level,
    input  logic               published_pending,
    output bmms_pkg::result_t  result
);

    logic [7:0]             hold_countdown_reg, hold_countdown_next;
    logic [6:0]             press_counter_reg, press_counter_next;
    logic [UPTIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic                   press_in_play_reg, press_in_play_next;
    logic                   led_state_reg, led_state_next;

    logic [UPTIME_BITS-1:0] elapsed_inc;
    logic [6:0]             count_inc;
    logic                   shutdown;
    logic                   pub_valid;
    logic [6:0]             pub_state;

    assign elapsed_inc = elapsed_reg + UPTIME_BITS'(bmms_pkg::TICK_MS);
    assign count_inc   = press_counter_reg + 7'd1;

    always_comb
    begin
        hold_countdown_next = hold_countdown_reg;
        press_counter_next  = press_counter_reg;
        elapsed_next        = elapsed_reg;
        press_in_play_next  = press_in_play_reg;
        led_state_next      = led_state_reg;
        shutdown            = 1'b0;
        pub_valid           = 1'b0;
        pub_state           = 7'd0;

        if (func == bmms_pkg::FUNC_PRESS)
        begin
            hold_countdown_next = cfg.turnoff_ticks;
            led_state_next      = 1'b1;
        end
        else
        begin
            elapsed_next = elapsed_inc;
            if (hold_countdown_reg != 8'd0)
            begin
                if (button_level)
                begin
                    hold_countdown_next = hold_countdown_reg - 8'd1;
                    shutdown            = (hold_countdown_reg == 8'd1);
                end
                else
                begin
                    led_state_next      = 1'b0;
                    hold_countdown_next = 8'd0;
                    if (hold_countdown_reg < cfg.debounce_threshold)
                    begin
                        elapsed_next       = '0;
                        press_in_play_next = 1'b1;
                        press_counter_next = (count_inc >= cfg.state_count) ? 7'd0 : count_inc;
                    end
                end
            end
            if (press_in_play_next && (hold_countdown_next == 8'd0) &&
                (elapsed_next > UPTIME_BITS'(cfg.multipress_timeout_ms)))
            begin
                if (!published_pending)
                begin
                    pub_valid = 1'b1;
                    pub_state = press_counter_next;
                end
                press_counter_next = 7'd0;
                press_in_play_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_countdown_reg <= 8'd0;
            press_counter_reg  <= 7'd0;
            elapsed_reg        <= '0;
            press_in_play_reg  <= 1'b0;
            led_state_reg      <= 1'b0;
        end
        else if (in_fire)
        begin
            hold_countdown_reg <= hold_countdown_next;
            press_counter_reg  <= press_counter_next;
            elapsed_reg        <= elapsed_next;
            press_in_play_reg  <= press_in_play_next;
            led_state_reg      <= led_state_next;
        end
    end

    assign result.shutdown_request = shutdown;
    assign result.led_on           = led_state_next;
    assign result.publish_valid    = pub_valid;
    assign result.published_state  = pub_state;
    assign result.press_count      = press_counter_next;

`ifndef SYNTHESIS
    a_pub_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && pub_valid |=> press_counter_reg == 7'd0 && !press_in_play_reg)
        else $error("publish did not clear press count");

    a_pub_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && pub_valid |-> !published_pending && func == bmms_pkg::FUNC_TICK)
        else $error("publish while pending or on press beat");

    a_shutdown_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && shutdown |=> hold_countdown_reg == 8'd0 && $past(button_level))
        else $error("shutdown without held button");

    a_press_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && func == bmms_pkg::FUNC_PRESS |=>
        hold_countdown_reg == $past(cfg.turnoff_ticks) && led_state_reg)
        else $error("press beat did not load countdown");
`endif

endmodule

// ----- hdl/button_multipress_mode_selector_top.sv -----
// ---------------------------------------------------------------------------
// button_multipress_mode_selector_top - multipress mode selector top level
// Configuration registers, press tracking core and two-entry result buffer.
// ---------------------------------------------------------------------------
// Takes one beat per clock while in_ready is high: a press edge (func=1) or a
// 10 ms tick carrying the button level (func=0), and returns exactly one result
// beat for each. The result is registered into the output entry, or into the
// skid entry while the output entry is held. A two-entry output buffer keeps
// input accepting while one result waits; in_ready drops only when both
// entries are full. Configuration writes are single-cycle with no read-back
// and should be issued while no result is outstanding.
// ---------------------------------------------------------------------------
module button_multipress_mode_selector_top #(
    parameter int UPTIME_BITS = bmms_pkg::UPTIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [bmms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmms_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic                            button_level,
    input  logic                            published_pending,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            shutdown_request,
    output logic                            led_on,
    output logic                            publish_valid,
    output logic [6:0]                      published_state,
    output logic [6:0]                      press_count
);

    bmms_pkg::cfg_t    cfg_reg;
    bmms_pkg::result_t core_result;
    bmms_pkg::result_t out_reg, out_next;
    bmms_pkg::result_t skid_reg, skid_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic              in_fire;
    logic              out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.turnoff_ticks         <= bmms_pkg::RST_TURNOFF_TICKS;
            cfg_reg.debounce_threshold    <= bmms_pkg::RST_DEBOUNCE_THR;
            cfg_reg.multipress_timeout_ms <= bmms_pkg::RST_MP_TIMEOUT;
            cfg_reg.state_count           <= bmms_pkg::RST_STATE_COUNT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bmms_pkg::CFG_TURNOFF_TICKS: cfg_reg.turnoff_ticks <= cfg_data[7:0];
                bmms_pkg::CFG_DEBOUNCE_THR:  cfg_reg.debounce_threshold <= cfg_data[7:0];
                bmms_pkg::CFG_MP_TIMEOUT:    cfg_reg.multipress_timeout_ms <= cfg_data;
                bmms_pkg::CFG_STATE_COUNT:   cfg_reg.state_count <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_take = out_valid_reg && out_ready;

    bmms_core #(
        .UPTIME_BITS(UPTIME_BITS)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .in_fire           (in_fire),
        .func              (func),
        .button_level      (button_level),
        .published_pending (published_pending),
        .result            (core_result)
    );

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_next       = core_result;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            skid_next       = core_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid        = out_valid_reg;
    assign shutdown_request = out_reg.shutdown_request;
    assign led_on           = out_reg.led_on;
    assign publish_valid    = out_reg.publish_valid;
    assign published_state  = out_reg.published_state;
    assign press_count      = out_reg.press_count;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_ready |=> skid_valid_reg && out_valid_reg)
        else $error("buffer lost a result while stalled");

    a_accept_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted beat produced no result");
`endif

endmodule
